// File: hw/rtl/mtkte_pkg.sv
// ----------------------------------------------------------------------------
// mtkte_pkg
// Shared types and constants for the multi-tap keypad text entry block.
// ----------------------------------------------------------------------------
package mtkte_pkg;

   localparam int unsigned LenWidth  = 5;
   localparam int unsigned KeyWidth  = 4;
   localparam int unsigned CharWidth = 8;
   localparam int unsigned TapWidth  = 2;

   localparam logic [LenWidth-1:0]  MaxLengthReset = 5'd5;

   // key codes
   localparam logic [KeyWidth-1:0]  KeyMode      = 4'd1;
   localparam logic [KeyWidth-1:0]  KeyTextFirst = 4'd2;
   localparam logic [KeyWidth-1:0]  KeyTextLast  = 4'd9;

   localparam logic [CharWidth-1:0] AsciiZero = 8'h30;

   // letter groups whose size is four rather than three (pqrs, wxyz)
   localparam logic [2:0] GroupPqrs = 3'd5;
   localparam logic [2:0] GroupWxyz = 3'd7;

   typedef struct packed {
      logic                 wrote;
      logic [LenWidth-1:0]  write_pos;
      logic [CharWidth-1:0] write_char;
      logic [LenWidth-1:0]  text_length;
      logic                 number_mode;
   } result_type;

   // first letter of each key's group
   function automatic logic [CharWidth-1:0] group_base(input logic [2:0] grp);
      logic [CharWidth-1:0] base;
      unique case (grp)
         3'd0: base = 8'h61;  // a
         3'd1: base = 8'h64;  // d
         3'd2: base = 8'h67;  // g
         3'd3: base = 8'h6a;  // j
         3'd4: base = 8'h6d;  // m
         3'd5: base = 8'h70;  // p
         3'd6: base = 8'h74;  // t
         3'd7: base = 8'h77;  // w
         default: base = 8'h61;
      endcase
      return base;
   endfunction

endpackage

// File: hw/rtl/multi_tap_keypad_text_entry.sv
// ----------------------------------------------------------------------------
// multi_tap_keypad_text_entry
// Multi-tap keypad text entry: one key per beat in, one write report out.
// ----------------------------------------------------------------------------
// One key is taken per clock cycle while req_stall is low. The state update
// (length, mode, last key, tap count) is a table lookup and compare done in
// the accepting cycle and the report is registered, so the rate is set only
// by the output side: a result register plus a one-deep skid register sit on
// the rsp_ port, and req_stall rises only when both are full. The csr_
// register sets the text limit and should be written while idle.
module multi_tap_keypad_text_entry (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mtkte_pkg::KeyWidth-1:0] req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_wrote,
   output logic [mtkte_pkg::LenWidth-1:0] rsp_write_pos,
   output logic [mtkte_pkg::CharWidth-1:0] rsp_write_char,
   output logic [mtkte_pkg::LenWidth-1:0] rsp_text_length,
   output logic                          rsp_number_mode,
   input  logic                          csr_write_enable,
   input  logic [mtkte_pkg::LenWidth-1:0] csr_write_data
);
   import mtkte_pkg::*;

   logic [LenWidth-1:0] max_length_ff;
   logic [LenWidth-1:0] length_ff, length_in;
   logic                mode_ff, mode_in;
   logic [KeyWidth-1:0] prev_key_ff, prev_key_in;
   logic [TapWidth-1:0] tap_ff, tap_in;

   result_type          res;
   result_type          out_ff;
   logic                out_valid_ff;
   result_type          skid_ff;
   logic                skid_valid_ff;

   logic                accept;
   logic                out_free;
   logic                text_key;
   logic [KeyWidth-1:0] key_off;
   logic [2:0]          grp;
   logic                has_room;
   logic [TapWidth:0]   tap_inc;
   logic [TapWidth-1:0] tap_wrap;

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;

   assign text_key = (req_key >= KeyTextFirst) && (req_key <= KeyTextLast);
   assign key_off  = req_key - KeyTextFirst;
   assign grp      = key_off[2:0];
   assign has_room = length_ff < max_length_ff;

   // next tap index, modulo the group size (3 or 4)
   assign tap_inc = {1'b0, tap_ff} + {{TapWidth{1'b0}}, 1'b1};
   always_comb begin
      if (grp == GroupPqrs || grp == GroupWxyz) begin
         tap_wrap = tap_inc[TapWidth-1:0];
      end else if (tap_inc >= 3'd3) begin
         tap_wrap = 2'(tap_inc - 3'd3);
      end else begin
         tap_wrap = tap_inc[TapWidth-1:0];
      end
   end

   always_comb begin
      length_in   = length_ff;
      mode_in     = mode_ff;
      prev_key_in = prev_key_ff;
      tap_in      = tap_ff;
      res         = '0;
      if (req_key == KeyMode) begin
         mode_in     = !mode_ff;
         prev_key_in = '0;
         tap_in      = '0;
      end else if (mode_ff) begin
         if (text_key && has_room) begin
            res.wrote      = 1'b1;
            res.write_pos  = length_ff;
            res.write_char = AsciiZero + {{(CharWidth-KeyWidth){1'b0}}, req_key};
            length_in      = length_ff + 5'd1;
         end
         prev_key_in = '0;
         tap_in      = '0;
      end else begin
         if (text_key) begin
            if (prev_key_ff == req_key && length_ff != '0) begin
               // same key again: overwrite the last character
               tap_in         = tap_wrap;
               res.wrote      = 1'b1;
               res.write_pos  = length_ff - 5'd1;
               res.write_char = group_base(grp) + {{(CharWidth-TapWidth){1'b0}}, tap_wrap};
            end else if (has_room) begin
               res.wrote      = 1'b1;
               res.write_pos  = length_ff;
               res.write_char = group_base(grp);
               length_in      = length_ff + 5'd1;
               tap_in         = '0;
            end
         end
         prev_key_in = req_key;
      end
      res.text_length = length_in;
      res.number_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MaxLengthReset;
      end else if (csr_write_enable) begin
         max_length_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         mode_ff     <= 1'b1;
         prev_key_ff <= '0;
         tap_ff      <= '0;
      end else if (accept) begin
         length_ff   <= length_in;
         mode_ff     <= mode_in;
         prev_key_ff <= prev_key_in;
         tap_ff      <= tap_in;
      end
   end

   // result register with a one-deep skid behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= res;
         end
      end else if (accept) begin
         skid_ff <= res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_wrote       = out_ff.wrote;
   assign rsp_write_pos   = out_ff.write_pos;
   assign rsp_write_char  = out_ff.write_char;
   assign rsp_text_length = out_ff.text_length;
   assign rsp_number_mode = out_ff.number_mode;

endmodule

// File: hw/rtl/mtkte_checker.sv
// ----------------------------------------------------------------------------
// mtkte_checker
// Port-level checks for the multi-tap keypad text entry block.
// ----------------------------------------------------------------------------
module mtkte_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic                          rsp_wrote,
   input logic [mtkte_pkg::LenWidth-1:0] rsp_write_pos,
   input logic [mtkte_pkg::CharWidth-1:0] rsp_write_char,
   input logic [mtkte_pkg::LenWidth-1:0] rsp_text_length,
   input logic                          rsp_number_mode
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_char)
         && $stable(rsp_text_length) && $stable(rsp_wrote))
      else $error("stalled rsp beat changed");

   // a beat that writes nothing carries a zero position and character
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wrote |-> rsp_write_pos == 5'd0 && rsp_write_char == 8'd0)
      else $error("no write but position or character nonzero");

   // a write always lands inside the text
   a_pos_in_text: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wrote |-> rsp_write_pos < rsp_text_length)
      else $error("write position beyond text length");

   // digit mode only writes digits 2 to 9
   a_digit_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_wrote && rsp_number_mode
         |-> rsp_write_char >= 8'h32 && rsp_write_char <= 8'h39)
      else $error("number mode wrote a non-digit");

endmodule

bind multi_tap_keypad_text_entry mtkte_checker u_mtkte_checker (.*);

// File: tb/sv/tb_multi_tap_keypad_text_entry.sv
// ----------------------------------------------------------------------------
// tb_multi_tap_keypad_text_entry
// Self-checking bench for the multi-tap keypad text entry block.
// ----------------------------------------------------------------------------
// Each accepted key is run through a local predictor of the mode, length, last
// key and tap count; its report, or the given one for a typed step, is queued.
// Every report beat is checked field by field against the oldest queued one.
// A directed table walks digits, letter cycling, full text, invalid keys, limit
// changes; then random key runs follow under several text limits, with random
// gaps on both sides and one long receiver hold-off that backs the block up.
module tb_multi_tap_keypad_text_entry;
   timeunit 1ns;
   timeprecision 1ps;

   import mtkte_pkg::*;

   localparam int HoldOffCycles = 60;
   localparam int WatchdogLimit = 2000;
   localparam int RandomPhases  = 6;
   localparam int KeysPerPhase  = 250;
   localparam logic [KeyWidth-1:0] KeyNone = 4'd0;
   localparam logic [KeyWidth-1:0] KeyTop  = 4'd15;
   localparam logic [LenWidth-1:0] LimitTop = 5'd31;

   typedef enum logic {StepKey, StepLimit} step_kind_type;

   typedef struct {
      step_kind_type       kind;
      logic [LenWidth-1:0] value;
      bit                  typed;
      result_type          report;
   } step_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [KeyWidth-1:0]   req_key;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_wrote;
   logic [LenWidth-1:0]   rsp_write_pos;
   logic [CharWidth-1:0]  rsp_write_char;
   logic [LenWidth-1:0]   rsp_text_length;
   logic                  rsp_number_mode;
   logic                  csr_write_enable;
   logic [LenWidth-1:0]   csr_write_data;

   // predicted entry state
   logic [LenWidth-1:0]   text_limit;
   logic [LenWidth-1:0]   text_len;
   logic                  digit_mode;
   logic [KeyWidth-1:0]   held_key;
   logic [TapWidth-1:0]   taps;

   // first letter and letter count of each key group, keys 2 to 9
   logic [CharWidth-1:0]  letter_first [8] = '{8'h61, 8'h64, 8'h67, 8'h6a,
                                                8'h6d, 8'h70, 8'h74, 8'h77};
   int unsigned           letter_span  [8] = '{3, 3, 3, 3, 3, 4, 3, 4};

   result_type            due_reports [$];
   step_type              steps [$];
   int                    mismatch_count;
   int                    quiet_cycles;
   int unsigned           calm_gaps_left;
   bit                    hold_off_req;
   bit                    hold_off_active;

   multi_tap_keypad_text_entry dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_wrote        (rsp_wrote),
      .rsp_write_pos    (rsp_write_pos),
      .rsp_write_char   (rsp_write_char),
      .rsp_text_length  (rsp_text_length),
      .rsp_number_mode  (rsp_number_mode),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic result_type key_report(input logic [KeyWidth-1:0] k);
      result_type  r;
      logic        text_key;
      logic [2:0]  grp;
      r = '0;
      text_key = (k >= KeyTextFirst) && (k <= KeyTextLast);
      grp = 3'(k - KeyTextFirst);
      if (k == KeyMode) begin
         digit_mode = ~digit_mode;
         held_key = '0;
         taps = '0;
      end else if (digit_mode) begin
         if (text_key && text_len < text_limit) begin
            r.wrote = 1'b1;
            r.write_pos = text_len;
            r.write_char = AsciiZero + CharWidth'(k);
            text_len = text_len + 1'b1;
         end
         held_key = '0;
         taps = '0;
      end else begin
         if (text_key) begin
            if (held_key == k && text_len != '0) begin
               // cycles from whatever count is left, even a stale one
               taps = TapWidth'((int'(taps) + 1) % letter_span[grp]);
               r.wrote = 1'b1;
               r.write_pos = text_len - 1'b1;
               r.write_char = letter_first[grp] + CharWidth'(taps);
            end else if (text_len < text_limit) begin
               r.wrote = 1'b1;
               r.write_pos = text_len;
               r.write_char = letter_first[grp];
               text_len = text_len + 1'b1;
               taps = '0;
            end
         end
         held_key = k;
      end
      r.text_length = text_len;
      r.number_mode = digit_mode;
      return r;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned pick;
      if (hold_off_req || hold_off_active) return 0;
      if (calm_gaps_left > 0) begin
         calm_gaps_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         calm_gaps_left = $urandom_range(20, 80);
         return 0;
      end
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic offer_key(input logic [KeyWidth-1:0] k, input bit typed,
                            input result_type typed_report);
      result_type  predicted;
      int unsigned gap;
      req_valid <= 1'b1;
      req_key   <= k;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = key_report(k);
      due_reports.push_back(typed ? typed_report : predicted);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_limit(input logic [LenWidth-1:0] v);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      text_limit = v;
   endtask

   task automatic add_key(input logic [KeyWidth-1:0] k);
      steps.push_back('{StepKey, LenWidth'(k), 1'b0, '0});
   endtask

   task automatic add_typed(input logic [KeyWidth-1:0] k, input logic w,
                            input logic [LenWidth-1:0] p, input logic [CharWidth-1:0] c,
                            input logic [LenWidth-1:0] l, input logic m);
      steps.push_back('{StepKey, LenWidth'(k), 1'b1, '{w, p, c, l, m}});
   endtask

   task automatic add_limit(input logic [LenWidth-1:0] v);
      steps.push_back('{StepLimit, v, 1'b0, '0});
   endtask

   task automatic check_field(input string field, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // receiver stall pattern, with one long hold-off on request
   initial begin : drive_rsp_stall
      int unsigned stall_left;
      int unsigned calm_left;
      int unsigned pick;
      stall_left = 0;
      calm_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_active = 1'b1;
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off_active = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_stall <= 1'b0;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 20) begin
               calm_left = $urandom_range(10, 60);
               rsp_stall <= 1'b0;
            end else if (pick < 90) begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
            end else begin
               stall_left = $urandom_range(5, 25);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_reports
      result_type want;
      if (!reset) begin
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (due_reports.size() == 0) begin
               $display("%0t: report beat with none expected", $time);
               mismatch_count++;
            end else begin
               want = due_reports.pop_front();
               check_field("wrote", 8'(want.wrote), 8'(rsp_wrote));
               check_field("write_pos", 8'(want.write_pos), 8'(rsp_write_pos));
               check_field("write_char", want.write_char, rsp_write_char);
               check_field("text_length", 8'(want.text_length), 8'(rsp_text_length));
               check_field("number_mode", 8'(want.number_mode), 8'(rsp_number_mode));
            end
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin : run_keys
      int          phase;
      int          issued;
      int unsigned pick;
      int unsigned run_len;
      logic [KeyWidth-1:0] k;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_key          <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      mismatch_count = 0;
      quiet_cycles = 0;
      calm_gaps_left = 0;
      hold_off_req = 1'b0;
      hold_off_active = 1'b0;
      text_limit = MaxLengthReset;
      text_len = '0;
      digit_mode = 1'b1;
      held_key = '0;
      taps = '0;

      // digits, invalid keys, then letter cycling in the pqrs and wxyz groups
      add_typed(4'd2,  1'b1, 5'd0, 8'h32, 5'd1, 1'b1);
      add_typed(4'd9,  1'b1, 5'd1, 8'h39, 5'd2, 1'b1);
      add_typed(KeyNone, 1'b0, 5'd0, 8'h00, 5'd2, 1'b1);
      add_typed(KeyTop, 1'b0, 5'd0, 8'h00, 5'd2, 1'b1);
      add_typed(KeyMode, 1'b0, 5'd0, 8'h00, 5'd2, 1'b0);
      add_typed(4'd7,  1'b1, 5'd2, 8'h70, 5'd3, 1'b0);
      repeat (4) add_key(4'd7);
      add_key(4'd9);
      add_key(4'd9);
      add_key(4'd2);
      // text full: append skipped, then a cycle from the leftover count
      add_typed(4'd3,  1'b0, 5'd0, 8'h00, 5'd5, 1'b0);
      add_key(4'd3);
      add_typed(4'd12, 1'b0, 5'd0, 8'h00, 5'd5, 1'b0);
      add_typed(4'd12, 1'b0, 5'd0, 8'h00, 5'd5, 1'b0);
      add_limit(LimitTop);
      repeat (4) add_key(4'd9);
      // limit below the length, then letter cycling on from a four-letter group's count
      add_limit(5'd1);
      add_typed(4'd2,  1'b0, 5'd0, 8'h00, 5'd6, 1'b0);
      add_key(4'd2);
      add_limit(5'd0);
      add_typed(KeyMode, 1'b0, 5'd0, 8'h00, 5'd6, 1'b1);
      add_typed(4'd5,  1'b0, 5'd0, 8'h00, 5'd6, 1'b1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (steps[i]) begin
         if (steps[i].kind == StepLimit)
            set_limit(steps[i].value);
         else
            offer_key(KeyWidth'(steps[i].value), steps[i].typed, steps[i].report);
      end

      for (phase = 0; phase < RandomPhases; phase++) begin
         set_limit(phase == RandomPhases - 1 ? LimitTop : LenWidth'($urandom_range(1, 31)));
         if (phase == 0) hold_off_req = 1'b1;
         issued = 0;
         while (issued < KeysPerPhase) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               offer_key(KeyMode, 1'b0, '0);
               issued++;
            end else if (pick < 14) begin
               k = ($urandom_range(0, 6) == 0) ? KeyNone
                   : KeyWidth'($urandom_range(KeyTextLast + 1, KeyTop));
               offer_key(k, 1'b0, '0);
               issued++;
            end else if (pick < 18) begin
               offer_key(KeyWidth'($urandom_range(0, KeyTop)), 1'b0, '0);
               issued++;
            end else begin
               // a run of taps on one text key
               k = KeyWidth'($urandom_range(KeyTextFirst, KeyTextLast));
               run_len = $urandom_range(1, 5);
               repeat (run_len) offer_key(k, 1'b0, '0);
               issued += run_len;
            end
         end
      end

      wait_idle();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
